FILE: rtl/core/bct_pkg.sv
// Shared types and constants for the bus contention timer.
`default_nettype none

package bct_pkg;

  localparam int unsigned TimeBitsDefault = 48;
  localparam int unsigned BytesW  = 13;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned RatioW  = 8;
  localparam int unsigned WidthW  = 3;
  localparam int unsigned ArbW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  // Multiplier factor: arbitration plus rounded-up beats needs one bit over the size.
  localparam int unsigned FactorW = BytesW + 1;
  localparam int unsigned CostW   = RatioW + FactorW;

  localparam logic [FactorW-1:0] PktOverhead   = FactorW'(6);
  localparam logic [FactorW-1:0] PktWriteExtra = FactorW'(1);

  typedef enum logic [CmdW-1:0] {
    CmdReadReq  = 2'd0,
    CmdReadResp = 2'd1,
    CmdWriteReq = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPacketBusMode   = 3'd0,
    CfgQueuingEnable   = 3'd1,
    CfgClockRatio      = 3'd2,
    CfgWidthLog2       = 3'd3,
    CfgArbitrationCyc  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              packet_bus_mode;
    logic              queuing_enable;
    logic [RatioW-1:0] clock_ratio;
    logic [WidthW-1:0] width_log2;
    logic [ArbW-1:0]   arbitration_cycles;
  } cfg_t;

  typedef struct packed {
    logic [CostW-1:0] response;
    logic [CostW-1:0] service;
  } cost_t;

endpackage

`default_nettype wire

FILE: rtl/core/bus_contention_timer.sv
// A result reaches the outputs through the input register and then the result register.
// Throughput: one request per cycle while the result is not stalled; the bus-free-time and counter registers
// are read and rewritten in the same cycle, so each request sees the previous one.
// Request costs are multiplied out before the input register, the timeline
// update runs between the input register and the result register.
// Reset clears the pipeline, the timeline state and counters, and loads config defaults.
`default_nettype none

module bus_contention_timer #(
  parameter int unsigned TIME_BITS = bct_pkg::TimeBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bct_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bct_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [TIME_BITS-1:0]           arrival_time_i,
  input  logic [bct_pkg::BytesW-1:0]     request_bytes_i,
  input  logic [bct_pkg::CmdW-1:0]       command_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [TIME_BITS-1:0]           wait_cycles_o,
  output logic                           causality_error_o,
  output logic [31:0]                    request_total_o,
  output logic signed [TIME_BITS-1:0]    idle_total_o,
  output logic [TIME_BITS-1:0]           queued_total_o,
  output logic [TIME_BITS-1:0]           free_at_o
);
  import bct_pkg::*;

  cfg_t  cfg_q;
  cost_t cost_in;

  logic                 in_accept;
  logic                 advance;
  logic                 s1_valid_q;
  logic [TIME_BITS-1:0] s1_arrival_q;
  cost_t                s1_cost_q;

  logic                 out_valid_q;
  logic [TIME_BITS-1:0] wait_q, wait_d;
  logic                 err_q;

  logic [TIME_BITS-1:0]        bus_free_q, bus_free_d;
  logic [TIME_BITS-1:0]        last_arr_q, last_arr_d;
  logic [31:0]                 req_cnt_q, req_cnt_d;
  logic signed [TIME_BITS-1:0] idle_q, idle_d;
  logic [TIME_BITS-1:0]        queued_q, queued_d;

  logic                 late;
  logic                 busy;
  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS-1:0] response_ext;
  logic [TIME_BITS-1:0] service_ext;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_bus_mode    <= 1'b0;
      cfg_q.queuing_enable     <= 1'b1;
      cfg_q.clock_ratio        <= RatioW'(1);
      cfg_q.width_log2         <= WidthW'(3);
      cfg_q.arbitration_cycles <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPacketBusMode:  cfg_q.packet_bus_mode    <= cfg_wdata_i[0];
        CfgQueuingEnable:  cfg_q.queuing_enable     <= cfg_wdata_i[0];
        CfgClockRatio:     cfg_q.clock_ratio        <= cfg_wdata_i[RatioW-1:0];
        CfgWidthLog2:      cfg_q.width_log2         <= cfg_wdata_i[WidthW-1:0];
        CfgArbitrationCyc: cfg_q.arbitration_cycles <= cfg_wdata_i[ArbW-1:0];
        default: ;
      endcase
    end
  end

  bct_cost u_cost (
    .cfg_i           (cfg_q),
    .request_bytes_i (request_bytes_i),
    .command_i       (command_i),
    .cost_o          (cost_in)
  );

  // The input register may refill while a finished result is still stalled.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_arrival_q <= arrival_time_i;
      s1_cost_q    <= cost_in;
    end
  end

  // Timeline update.
  assign response_ext = TIME_BITS'(s1_cost_q.response);
  assign service_ext  = TIME_BITS'(s1_cost_q.service);
  assign late = s1_arrival_q < last_arr_q;
  assign busy = cfg_q.queuing_enable && (bus_free_q > s1_arrival_q);
  assign gap  = bus_free_q - s1_arrival_q;

  always_comb begin
    bus_free_d = bus_free_q;
    last_arr_d = last_arr_q;
    req_cnt_d  = req_cnt_q;
    idle_d     = idle_q;
    queued_d   = queued_q;
    wait_d     = '0;
    if (!late) begin
      last_arr_d = s1_arrival_q;
      req_cnt_d  = req_cnt_q + 32'd1;
      if (busy) begin
        queued_d   = queued_q + gap;
        bus_free_d = bus_free_q + service_ext;
        wait_d     = gap + response_ext;
      end else begin
        idle_d     = idle_q - $signed(gap);
        bus_free_d = s1_arrival_q + service_ext;
        wait_d     = response_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bus_free_q  <= '0;
      last_arr_q  <= '0;
      req_cnt_q   <= '0;
      idle_q      <= '0;
      queued_q    <= '0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        bus_free_q <= bus_free_d;
        last_arr_q <= last_arr_d;
        req_cnt_q  <= req_cnt_d;
        idle_q     <= idle_d;
        queued_q   <= queued_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      wait_q <= wait_d;
      err_q  <= late;
    end
  end

  // State only moves together with the result register, so it doubles as the payload.
  assign out_valid_o       = out_valid_q;
  assign wait_cycles_o     = wait_q;
  assign causality_error_o = err_q;
  assign request_total_o   = req_cnt_q;
  assign idle_total_o      = idle_q;
  assign queued_total_o    = queued_q;
  assign free_at_o         = bus_free_q;

`ifndef ASSERT_OFF
  a_err_zero_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && causality_error_o |-> wait_cycles_o == '0)
    else $error("error result carries a nonzero wait");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance && !late |=> req_cnt_q == $past(req_cnt_q) + 32'd1)
    else $error("request counter did not step on an accepted request");

  a_arrival_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> last_arr_q >= $past(last_arr_q))
    else $error("last arrival moved backward");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(bus_free_q) && $stable(req_cnt_q))
    else $error("timeline state changed under a stalled result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bct_cost.sv
// Response and service time of one request from its size, kind and the bus setup.
`default_nettype none

module bct_cost (
  input  bct_pkg::cfg_t                cfg_i,
  input  logic [bct_pkg::BytesW-1:0]   request_bytes_i,
  input  logic [bct_pkg::CmdW-1:0]     command_i,
  output bct_pkg::cost_t               cost_o
);
  import bct_pkg::*;

  logic [FactorW-1:0] width_mask;
  logic [FactorW-1:0] ceil_beats;
  logic [FactorW-1:0] floor_beats;
  logic [FactorW-1:0] arb_ext;
  logic [FactorW-1:0] write_fac;
  logic [FactorW-1:0] resp_fac;
  logic [FactorW-1:0] serv_fac;

  assign width_mask  = (FactorW'(1) << cfg_i.width_log2) - FactorW'(1);
  assign ceil_beats  = (FactorW'(request_bytes_i) + width_mask) >> cfg_i.width_log2;
  assign floor_beats = FactorW'(request_bytes_i >> cfg_i.width_log2);
  assign arb_ext     = FactorW'(cfg_i.arbitration_cycles);
  assign write_fac   = PktOverhead + PktWriteExtra + floor_beats;

  always_comb begin
    if (cfg_i.packet_bus_mode) begin
      case (cmd_e'(command_i))
        CmdReadReq: begin
          resp_fac = PktOverhead;
          serv_fac = PktOverhead;
        end
        CmdReadResp: begin
          resp_fac = FactorW'(1);
          serv_fac = floor_beats;
        end
        CmdWriteReq: begin
          resp_fac = write_fac;
          serv_fac = write_fac;
        end
        default: begin
          // The unused code is timed as a write request.
          resp_fac = write_fac;
          serv_fac = write_fac;
        end
      endcase
    end else begin
      resp_fac = arb_ext + FactorW'(1);
      serv_fac = arb_ext + ceil_beats;
    end
  end

  assign cost_o.response = CostW'(cfg_i.clock_ratio) * CostW'(resp_fac);
  assign cost_o.service  = CostW'(cfg_i.clock_ratio) * CostW'(serv_fac);

endmodule

`default_nettype wire

FILE: sim/bus_contention_timer_checker.sv
// Checker that predicts the timing result of every bus request and compares it with the block.
module bus_contention_timer_checker
  import bct_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [TIME_BITS-1:0] arrival_time_i,
  input  logic [BytesW-1:0]    request_bytes_i,
  input  logic [CmdW-1:0]      command_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [TIME_BITS-1:0] wait_cycles_i,
  input  logic                 causality_error_i,
  input  logic [31:0]          request_total_i,
  input  logic [TIME_BITS-1:0] idle_total_i,
  input  logic [TIME_BITS-1:0] queued_total_i,
  input  logic [TIME_BITS-1:0] free_at_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 100;

  typedef struct packed {
    logic [TIME_BITS-1:0] wait_cycles;
    logic                 causality_error;
    logic [31:0]          request_total;
    logic [TIME_BITS-1:0] idle_total;
    logic [TIME_BITS-1:0] queued_total;
    logic [TIME_BITS-1:0] free_at;
  } timing_result_t;

  cfg_t                 bus_cfg;
  logic [TIME_BITS-1:0] bus_free_time;
  logic [TIME_BITS-1:0] last_arrival;
  logic [31:0]          request_count;
  logic [TIME_BITS-1:0] idle_count;
  logic [TIME_BITS-1:0] queued_count;
  timing_result_t       expected_results[$];

  // Advances the bus timeline by one request and returns what the block should report.
  function automatic timing_result_t time_request(input logic [TIME_BITS-1:0] arrival,
                                                  input logic [BytesW-1:0] size,
                                                  input logic [CmdW-1:0] cmd);
    logic [63:0]          ratio;
    logic [63:0]          beats;
    logic [63:0]          response;
    logic [63:0]          service;
    logic [TIME_BITS-1:0] delay;
    timing_result_t       res;
    res.causality_error = 1'b0;
    if (arrival < last_arrival) begin
      // Out-of-order arrival: nothing moves, the current state is shown.
      res.wait_cycles = '0;
      res.causality_error = 1'b1;
    end else begin
      request_count = request_count + 32'd1;
      last_arrival = arrival;
      ratio = 64'(bus_cfg.clock_ratio);
      if (bus_cfg.packet_bus_mode) begin
        beats = 64'(size) >> bus_cfg.width_log2;
        if (cmd == CmdReadReq) begin
          response = ratio * 64'(PktOverhead);
          service = response;
        end else if (cmd == CmdReadResp) begin
          response = ratio;
          service = ratio * beats;
        end else begin
          response = ratio * (64'(PktOverhead) + 64'(PktWriteExtra) + beats);
          service = response;
        end
      end else begin
        beats = (64'(size) + (64'd1 << bus_cfg.width_log2) - 64'd1) >> bus_cfg.width_log2;
        response = ratio * (64'(bus_cfg.arbitration_cycles) + 64'd1);
        service = ratio * (64'(bus_cfg.arbitration_cycles) + beats);
      end
      if (bus_cfg.queuing_enable && bus_free_time > arrival) begin
        delay = bus_free_time - arrival;
        queued_count = queued_count + delay;
        bus_free_time = bus_free_time + TIME_BITS'(service);
        res.wait_cycles = delay + TIME_BITS'(response);
      end else begin
        idle_count = idle_count + arrival - bus_free_time;
        bus_free_time = arrival + TIME_BITS'(service);
        res.wait_cycles = TIME_BITS'(response);
      end
    end
    res.request_total = request_count;
    res.idle_total = idle_count;
    res.queued_total = queued_count;
    res.free_at = bus_free_time;
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      fail_count_o++;
      if (fail_count_o <= ReportLimit) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timing_result_t due;
    if (!rst_ni) begin
      bus_cfg = '{packet_bus_mode: 1'b0, queuing_enable: 1'b1, clock_ratio: 8'd1,
                  width_log2: 3'd3, arbitration_cycles: 8'd0};
      bus_free_time = '0;
      last_arrival = '0;
      request_count = '0;
      idle_count = '0;
      queued_count = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $error("result accepted while no request was waiting for one");
        end else begin
          due = expected_results.pop_front();
          compare_field("wait_cycles", 64'(due.wait_cycles), 64'(wait_cycles_i));
          compare_field("causality_error", 64'(due.causality_error),
                        64'(causality_error_i));
          compare_field("request_total", 64'(due.request_total), 64'(request_total_i));
          compare_field("idle_total", 64'(due.idle_total), 64'(idle_total_i));
          compare_field("queued_total", 64'(due.queued_total), 64'(queued_total_i));
          compare_field("free_at", 64'(due.free_at), 64'(free_at_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPacketBusMode:  bus_cfg.packet_bus_mode = cfg_wdata_i[0];
          CfgQueuingEnable:  bus_cfg.queuing_enable = cfg_wdata_i[0];
          CfgClockRatio:     bus_cfg.clock_ratio = cfg_wdata_i[RatioW-1:0];
          CfgWidthLog2:      bus_cfg.width_log2 = cfg_wdata_i[WidthW-1:0];
          CfgArbitrationCyc: bus_cfg.arbitration_cycles = cfg_wdata_i[ArbW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(time_request(arrival_time_i, request_bytes_i, command_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: sim/bus_contention_timer_test.sv
// Testbench top: drives bus requests and settings into the contention timer and gives the verdict.
module bus_contention_timer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bct_pkg::*;

  localparam int unsigned TimeW = TimeBitsDefault;
  localparam logic [TimeW-1:0] LatestTime = '1;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettingRounds = 14;
  localparam int unsigned RequestsPerRound = 120;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [TimeW-1:0]    arrival_time = '0;
  logic [BytesW-1:0]   request_bytes = '0;
  logic [CmdW-1:0]     command = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [TimeW-1:0]    wait_cycles;
  logic                causality_error;
  logic [31:0]         request_total;
  logic signed [TimeW-1:0] idle_total;
  logic [TimeW-1:0]    queued_total;
  logic [TimeW-1:0]    free_at;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         requests_sent = 0;
  int unsigned         late_requests = 0;
  int unsigned         settings_used = 0;
  logic [TimeW-1:0]    latest_arrival = '0;

  bus_contention_timer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (req_valid),
    .in_stall_o       (req_stall),
    .arrival_time_i   (arrival_time),
    .request_bytes_i  (request_bytes),
    .command_i        (command),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .wait_cycles_o    (wait_cycles),
    .causality_error_o(causality_error),
    .request_total_o  (request_total),
    .idle_total_o     (idle_total),
    .queued_total_o   (queued_total),
    .free_at_o        (free_at)
  );

  bus_contention_timer_checker timing_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (req_valid),
    .in_stall_i       (req_stall),
    .arrival_time_i   (arrival_time),
    .request_bytes_i  (request_bytes),
    .command_i        (command),
    .out_valid_i      (res_valid),
    .out_stall_i      (res_stall),
    .wait_cycles_i    (wait_cycles),
    .causality_error_i(causality_error),
    .request_total_i  (request_total),
    .idle_total_i     (idle_total),
    .queued_total_i   (queued_total),
    .free_at_i        (free_at),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Ends the run when neither a request nor a result has moved for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $error("no request or result accepted for %0d cycles", QuietLimit);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic choose_idling(input int unsigned mode);
    case (mode)
      1: begin
        send_idle_pct = 71;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 71;
      end
      3: begin
        send_idle_pct = 19;
        stall_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic issue_request(input logic [TimeW-1:0] arrival, input logic [BytesW-1:0] size,
                               input logic [CmdW-1:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    arrival_time <= arrival;
    request_bytes <= size;
    command <= cmd;
    do @(posedge clk); while (req_stall);
    if (arrival < latest_arrival) begin
      late_requests++;
    end else begin
      latest_arrival = arrival;
    end
    requests_sent++;
  endtask

  // Mostly forward-moving arrivals spaced to mix contention and idle gaps; a few go backward.
  task automatic random_request();
    logic [TimeW:0]     ahead;
    logic [TimeW-1:0]   arrival;
    logic [BytesW-1:0]  size;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 5 && latest_arrival != 0) begin
      arrival = TimeW'({$urandom, $urandom} % 64'(latest_arrival));
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        ahead = {1'b0, latest_arrival};
      end else if (pick < 60) begin
        ahead = {1'b0, latest_arrival} + $urandom_range(64);
      end else if (pick < 90) begin
        ahead = {1'b0, latest_arrival} + $urandom_range(8192);
      end else begin
        ahead = {1'b0, latest_arrival} + $urandom_range(1 << 22);
      end
      arrival = (ahead > {1'b0, LatestTime}) ? LatestTime : ahead[TimeW-1:0];
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      size = '0;
    end else if (pick < 8) begin
      size = BytesW'($urandom_range(8191, 4097));
    end else if (pick < 50) begin
      size = BytesW'($urandom_range(64, 1));
    end else begin
      size = BytesW'($urandom_range(4096, 1));
    end
    issue_request(arrival, size, CmdW'($urandom_range(3)));
  endtask

  // Waits until every request has its result and the block has settled.
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic program_settings(input logic packet_mode, input logic queuing,
                                  input logic [RatioW-1:0] ratio,
                                  input logic [WidthW-1:0] width_log2,
                                  input logic [ArbW-1:0] arbitration);
    wait_for_results();
    write_register(CfgPacketBusMode, CfgDataW'(packet_mode));
    write_register(CfgQueuingEnable, CfgDataW'(queuing));
    write_register(CfgClockRatio, CfgDataW'(ratio));
    write_register(CfgWidthLog2, CfgDataW'(width_log2));
    write_register(CfgArbitrationCyc, CfgDataW'(arbitration));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [RatioW-1:0] ratio;
    logic [WidthW-1:0] width_log2;
    logic [ArbW-1:0]   arbitration;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: plain bus, queuing on, equal and backward arrivals, size extremes.
    issue_request(48'd0, 13'd1, CmdReadReq);
    issue_request(48'd0, 13'd4096, CmdWriteReq);
    issue_request(48'd10, 13'd8191, CmdUnused);
    issue_request(48'd5, 13'd64, CmdReadReq);
    issue_request(48'd10, 13'd0, CmdReadResp);
    issue_request(48'd100000, 13'd9, CmdReadReq);

    // Packet bus with the widest bus, so small transfers have no data beats.
    program_settings(1'b1, 1'b1, 8'd255, 3'd7, 8'd255);
    issue_request(48'd100000, 13'd100, CmdReadReq);
    issue_request(48'd100000, 13'd100, CmdReadResp);
    issue_request(48'd100001, 13'd4096, CmdWriteReq);
    issue_request(48'd100001, 13'd8191, CmdUnused);
    issue_request(48'd100002, 13'd128, CmdReadResp);

    // Queuing off while the bus is still busy, first with a zero clock ratio.
    program_settings(1'b0, 1'b0, 8'd0, 3'd0, 8'd255);
    issue_request(48'd100003, 13'd8191, CmdReadReq);
    issue_request(48'd100004, 13'd1, CmdWriteReq);
    issue_request(48'd100004, 13'd0, CmdReadResp);
    program_settings(1'b0, 1'b0, 8'd255, 3'd0, 8'd0);
    issue_request(48'd100005, 13'd8191, CmdWriteReq);
    issue_request(48'd100006, 13'd4096, CmdReadReq);
    issue_request(48'd100007, 13'd2, CmdReadResp);

    for (int unsigned round = 0; round < SettingRounds; round++) begin
      case (round % 4)
        0: ratio = 8'd255;
        1: ratio = 8'd1;
        2: ratio = (round == 6) ? 8'd0 : RatioW'($urandom_range(255, 1));
        default: ratio = RatioW'($urandom_range(16, 1));
      endcase
      case (round % 3)
        0: width_log2 = 3'd7;
        1: width_log2 = 3'd0;
        default: width_log2 = WidthW'($urandom_range(7));
      endcase
      case (round % 5)
        0: arbitration = 8'd255;
        1: arbitration = 8'd0;
        default: arbitration = ArbW'($urandom_range(15));
      endcase
      program_settings(round[0], ($urandom_range(3) != 0), ratio, width_log2, arbitration);
      choose_idling(round % 5);
      repeat (RequestsPerRound) random_request();
    end

    // Near the end of the time range so the free time wraps and the top arrival bits toggle.
    program_settings(1'($urandom_range(1)), 1'b1, 8'd255, 3'd0, 8'd255);
    choose_idling(3);
    issue_request(LatestTime - TimeW'($urandom_range(1 << 24)), 13'd4096, CmdWriteReq);
    repeat (60) random_request();
    issue_request(LatestTime, 13'd4096, CmdWriteReq);
    issue_request(LatestTime, 13'd1, CmdReadReq);
    repeat (20) random_request();

    wait_for_results();
    $display("Sent %0d requests (%0d arriving out of order) under %0d bus settings,",
             requests_sent, late_requests, settings_used + 1);
    $display("with plain and packet timing, queuing on and off, and all idle patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
